/* rtl/core/smbs_pkg.sv */
// ----------------------------------------------------------------------------
// smbs_pkg
// Shared constants, codes and controller/datapath interface types for the
// sorted matrix binary search core.
// ----------------------------------------------------------------------------
package smbs_pkg;

	localparam int MAX_ELEMENTS_DEF  = 1024;
	localparam int ELEMENT_WIDTH_DEF = 32;

	localparam int VALUE_W    = 32;
	localparam int POS_W      = 10;
	localparam int CFG_W      = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 8;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

	typedef struct packed {
		logic init;   // capture target, set bounds from matrix size
		logic load;   // write one element
		logic first;  // issue first probe
		logic step;   // evaluate probe, narrow bounds, issue next probe
		logic emit;   // move result into output register
	} smbs_cmd_t;

	typedef struct packed {
		logic first_empty;  // search range empty before any probe
		logic probe_done;   // current probe ends the search
	} smbs_sts_t;

endpackage

/* rtl/core/smbs_ram.sv */
// ----------------------------------------------------------------------------
// smbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/smbs_ctrl.sv */
// ----------------------------------------------------------------------------
// smbs_ctrl
// Sequencer for load and search transactions: accepts input, steps the
// probe loop and hands the result to the output register.
// ----------------------------------------------------------------------------
module smbs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic                opcode,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  smbs_pkg::smbs_sts_t sts,
	output smbs_pkg::smbs_cmd_t cmd
);
	import smbs_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_PROBE = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       m_tvalid_q;
	logic       accept_c;
	logic       out_free_c;

	assign s_tready   = (state_q == ST_IDLE);
	assign accept_c   = s_tvalid && s_tready;
	assign out_free_c = !m_tvalid_q || m_tready;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept_c) begin
					if (opcode == OP_SEARCH) begin
						cmd.init = 1'b1;
						state_d  = ST_START;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_START: begin
				cmd.first = 1'b1;
				state_d   = sts.first_empty ? ST_EMIT : ST_PROBE;
			end
			ST_PROBE: begin
				cmd.step = 1'b1;
				if (sts.probe_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free_c) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.init, cmd.load, cmd.first, cmd.step, cmd.emit}))
		else $error("more than one datapath command in a cycle");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> m_tvalid)
		else $error("emitted result not presented");

	a_search_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_c && opcode == OP_SEARCH) |=> (state_q == ST_START))
		else $error("search transaction did not start probing");

endmodule

/* rtl/core/smbs_dp.sv */
// ----------------------------------------------------------------------------
// smbs_dp
// Datapath: matrix size registers, element store, search bounds, probe
// address generation, compare and result register.
// ----------------------------------------------------------------------------
module smbs_dp #(
	parameter int MAX_ELEMENTS  = smbs_pkg::MAX_ELEMENTS_DEF,
	parameter int ELEMENT_WIDTH = smbs_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [smbs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [smbs_pkg::CFG_W-1:0]           cfg_data,
	input  logic signed [smbs_pkg::VALUE_W-1:0]  value,
	input  logic [smbs_pkg::POS_W-1:0]           position,
	input  smbs_pkg::smbs_cmd_t                  cmd,
	output smbs_pkg::smbs_sts_t                  sts,
	output logic                                 found
);
	import smbs_pkg::*;

	localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int BW    = $clog2(MAX_ELEMENTS + 1);
	localparam int PW    = 2 * CFG_W;
	localparam int EXT_W = 18;

	logic [CFG_W-1:0]                row_count_q;
	logic [CFG_W-1:0]                column_count_q;
	logic signed [ELEMENT_WIDTH-1:0] key_c;
	logic signed [ELEMENT_WIDTH-1:0] key_q;
	logic signed [ELEMENT_WIDTH-1:0] elem_c;
	logic [ELEMENT_WIDTH-1:0]        rdata;
	logic [BW-1:0]                   lo_q;
	logic [BW-1:0]                   hi_q;
	logic [BW-1:0]                   mid_q;
	logic                            res_hit_q;
	logic                            found_q;
	logic [PW-1:0]                   product_c;
	logic [BW-1:0]                   count_c;
	logic [BW:0]                     first_sum_c;
	logic [BW:0]                     lt_sum_c;
	logic [BW:0]                     gt_sum_c;
	logic [BW:0]                     mid_inc_c;
	logic [BW-1:0]                   first_mid_c;
	logic [BW-1:0]                   mid_lt_c;
	logic [BW-1:0]                   mid_gt_c;
	logic [BW-1:0]                   next_mid_c;
	logic                            eq_c;
	logic                            lt_c;
	logic                            lt_empty_c;
	logic                            gt_empty_c;
	logic                            pos_ok_c;

	// element key: the value sign-extended to the element width, or its low bits when narrower
	if (ELEMENT_WIDTH >= VALUE_W) begin : g_key_wide
		assign key_c = ELEMENT_WIDTH'(value);
	end else begin : g_key_narrow
		assign key_c = value[ELEMENT_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= CFG_W'(1);
			column_count_q <= CFG_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_COUNT:    row_count_q    <= cfg_data;
				REG_COLUMN_COUNT: column_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign product_c = PW'(row_count_q) * PW'(column_count_q);
	assign count_c   = (product_c > PW'(MAX_ELEMENTS)) ? BW'(MAX_ELEMENTS)
	                                                   : product_c[BW-1:0];

	assign pos_ok_c = EXT_W'(position) < EXT_W'(MAX_ELEMENTS);

	assign first_sum_c = {1'b0, lo_q} + {1'b0, hi_q} - (BW+1)'(1);
	assign lt_sum_c    = {1'b0, lo_q} + {1'b0, mid_q} - (BW+1)'(1);
	assign gt_sum_c    = {1'b0, mid_q} + {1'b0, hi_q};
	assign mid_inc_c   = {1'b0, mid_q} + (BW+1)'(1);
	assign first_mid_c = first_sum_c[BW:1];
	assign mid_lt_c    = lt_sum_c[BW:1];
	assign mid_gt_c    = gt_sum_c[BW:1];

	assign elem_c     = rdata;
	assign eq_c       = (key_q == elem_c);
	assign lt_c       = (key_q < elem_c);
	assign lt_empty_c = !(lo_q < mid_q);
	assign gt_empty_c = !(mid_inc_c < {1'b0, hi_q});

	assign next_mid_c = cmd.first ? first_mid_c : (lt_c ? mid_lt_c : mid_gt_c);

	assign sts.first_empty = !(lo_q < hi_q);
	assign sts.probe_done  = eq_c || (lt_c ? lt_empty_c : gt_empty_c);

	smbs_ram #(
		.WIDTH (ELEMENT_WIDTH),
		.DEPTH (MAX_ELEMENTS)
	) u_store (
		.clk   (clk),
		.we    (cmd.load && pos_ok_c),
		.waddr (AW'(position)),
		.wdata (key_c),
		.re    (cmd.first || cmd.step),
		.raddr (next_mid_c[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (cmd.init) begin
			lo_q <= '0;
			hi_q <= count_c;
		end else if (cmd.step && !eq_c) begin
			if (lt_c) begin
				hi_q <= mid_q;
			end else begin
				lo_q <= mid_inc_c[BW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			key_q     <= key_c;
			res_hit_q <= 1'b0;
		end
		if (cmd.first || cmd.step) begin
			mid_q <= next_mid_c;
		end
		if (cmd.step) begin
			res_hit_q <= eq_c;
		end
		if (cmd.emit) begin
			found_q <= res_hit_q;
		end
	end

	assign found = found_q;

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (lo_q <= mid_q && mid_q < hi_q))
		else $error("probe outside search range");

	a_bounds_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !eq_c) |=> ((hi_q - lo_q) < $past(hi_q - lo_q)))
		else $error("search range did not shrink");

endmodule

/* rtl/core/sorted_matrix_binary_search_core.sv */
// Load: taken while the controller is idle, one load transaction per cycle.
// Search: P probes of the element store, one per cycle through its registered read
//   port, P <= ceil(log2(rows*cols + 1)) (11 for 1024 entries); states run start,
//   probe, emit (held until the output is free) and back to idle for new input.
// Reset (arst_n, async): controller idle, output empty, bounds zero, rows and
//   columns one; the element store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
// sorted_matrix_binary_search_core
// Binary search over a row-major sorted matrix held in an element store.
// ----------------------------------------------------------------------------
module sorted_matrix_binary_search_core #(
	parameter int MAX_ELEMENTS  = smbs_pkg::MAX_ELEMENTS_DEF,
	parameter int ELEMENT_WIDTH = smbs_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [smbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [smbs_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [smbs_pkg::S_TDATA_W-1:0]   s_tdata,  // value[31:0], position[41:32]
	input  logic                             s_tuser,  // opcode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [smbs_pkg::M_TDATA_W-1:0]   m_tdata   // found[0]
);
	import smbs_pkg::*;

	smbs_cmd_t                 cmd;
	smbs_sts_t                 sts;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;
	logic                      found;

	assign value    = s_tdata[VALUE_W-1:0];
	assign position = s_tdata[VALUE_W +: POS_W];

	smbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	smbs_dp #(
		.MAX_ELEMENTS  (MAX_ELEMENTS),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.value     (value),
		.position  (position),
		.cmd       (cmd),
		.sts       (sts),
		.found     (found)
	);

	assign m_tdata = {{(M_TDATA_W-1){1'b0}}, found};

endmodule
